/* src/srs_pkg.sv */
// srs_pkg: shared types, register codes and the sine table builder for the
// sine row shift raster block. No dependencies; all but srs_if and srs_ram import it.

package srs_pkg;

	localparam int REG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_ROW_WIDTH   = 3'd0,
		REG_ROW_COUNT   = 3'd1,
		REG_AMPLITUDE   = 3'd2,
		REG_START_PHASE = 3'd3,
		REG_PHASE_STEP  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] row_width;
		logic [10:0] row_count;
		logic [11:0] amplitude;
		logic [15:0] start_phase;
		logic [15:0] phase_step;
	} cfg_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic valid;
		logic emit;
		logic first;
		logic rlast;
		logic flast;
	} ctl_t;

	// 2*pi in Q30
	localparam longint TWO_PI_Q30 = 64'sd6746518852;

	// (2n)(2n+1) for the Taylor terms n = 1..12
	localparam longint TAYLOR_DIV [12] = '{
		64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
		64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
	};

	// sin(2*pi*k/2^lg) in Q1.15 for the first quarter, rounded, saturated.
	// Only evaluated at elaboration to fill the sine table.
	function automatic int quarter_sine(int k, int lg);
		longint x;
		longint x2;
		longint term;
		longint acc;
		longint r;
		x = (TWO_PI_Q30 * longint'(k)) >>> lg;
		x2 = (x * x) >>> 30;
		term = x;
		acc = 0;
		for (int n = 1; n <= 12; n++) begin
			if (n % 2 == 1)
				acc = acc + term;
			else
				acc = acc - term;
			term = ((term * x2) >>> 30) / TAYLOR_DIV[n - 1];
		end
		if (acc < 0)
			acc = 0;
		r = (acc + 64'sd16384) >>> 15;
		if (r > 32767)
			r = 32767;
		return int'(r);
	endfunction

endpackage

/* src/srs_if.sv */
// srs_if: valid/ready stream interfaces for the pixel input and result channels.
// Depends on nothing.

interface srs_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] src_pixel;
	logic [31:0] dst_pixel;

	modport source (output valid, action, src_pixel, dst_pixel, input ready);
	modport sink   (input valid, action, src_pixel, dst_pixel, output ready);
endinterface

interface srs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;
	logic        row_last;
	logic        frame_last;

	modport source (output valid, out_pixel, row_last, frame_last, input ready);
	modport sink   (input valid, out_pixel, row_last, frame_last, output ready);
endinterface

/* src/srs_ram.sv */
// srs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module srs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* src/srs_sine_rom.sv */
// srs_sine_rom: quarter-wave sine table with mirrored addressing, registered output.
// Depends on srs_pkg (quarter_sine builder).

module srs_sine_rom #(
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [$clog2(SINE_ENTRIES)-1:0] idx,
	output logic [14:0]                     mag,
	output logic                            neg
);

	import srs_pkg::*;

	localparam int LN = $clog2(SINE_ENTRIES);
	localparam int QN = SINE_ENTRIES / 4;
	localparam int KW = LN - 1;

	logic [14:0]   qtab [QN + 1];
	logic [1:0]    quad;
	logic [LN-3:0] rem;
	logic [KW-1:0] k;

	for (genvar g = 0; g <= QN; g++) begin : g_tab
		localparam logic [14:0] VAL = 15'(quarter_sine(g, LN));
		assign qtab[g] = VAL;
	end

	assign quad = idx[LN-1 -: 2];
	assign rem  = idx[LN-3:0];
	// second and fourth quarters run backwards through the table
	assign k = quad[0] ? (KW'(QN) - KW'(rem)) : KW'(rem);

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= qtab[k];
			neg <= quad[1];
		end
	end

endmodule

/* src/srs_regs.sv */
// srs_regs: APB-style configuration register file.
// Depends on srs_pkg (cfg_t, reg_idx_t).

module srs_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [srs_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output srs_pkg::cfg_t                   cfg
);

	import srs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width   <= 11'd1024;
			cfg_q.row_count   <= 11'd1024;
			cfg_q.amplitude   <= '0;
			cfg_q.start_phase <= '0;
			cfg_q.phase_step  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_ROW_WIDTH:   cfg_q.row_width   <= pwdata[10:0];
				REG_ROW_COUNT:   cfg_q.row_count   <= pwdata[10:0];
				REG_AMPLITUDE:   cfg_q.amplitude   <= pwdata[11:0];
				REG_START_PHASE: cfg_q.start_phase <= pwdata[15:0];
				REG_PHASE_STEP:  cfg_q.phase_step  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW_WIDTH:   prdata = 32'(cfg_q.row_width);
			REG_ROW_COUNT:   prdata = 32'(cfg_q.row_count);
			REG_AMPLITUDE:   prdata = 32'(cfg_q.amplitude);
			REG_START_PHASE: prdata = 32'(cfg_q.start_phase);
			REG_PHASE_STEP:  prdata = 32'(cfg_q.phase_step);
			default:         prdata = '0;
		endcase
	end

endmodule

/* src/srs_seq.sv */
// srs_seq: load/emit column counters, row counter and phase accumulator;
// produces the first-stage control and the sine table index.
// Depends on srs_pkg (cfg_t, ctl_t).

module srs_seq #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_ROWS     = 1024,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            acc,
	input  logic                            action,
	input  srs_pkg::cfg_t                   cfg,
	output srs_pkg::ctl_t                   ctl_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]    col_s1,
	output logic [$clog2(SINE_ENTRIES)-1:0] rom_idx,
	output logic [$clog2(MAX_WIDTH):0]      w
);

	import srs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int HW = RW + 1;
	localparam int LN = $clog2(SINE_ENTRIES);

	logic [HW-1:0] h;
	logic [CW-1:0] load_col_q;
	logic [CW-1:0] emit_col_q;
	logic [RW-1:0] row_q;
	logic [15:0]   phase_acc_q;

	logic [CW-1:0] lcol;
	logic          lwrap;
	logic [CW-1:0] ecol;
	logic [RW-1:0] row;
	logic          first;
	logic          rlast;
	logic          flast;
	logic [15:0]   phase_cur;

	// zero counts as one, oversize saturates
	always_comb begin
		if (cfg.row_width == '0)
			w = WW'(1);
		else if (32'(cfg.row_width) > MAX_WIDTH)
			w = WW'(MAX_WIDTH);
		else
			w = WW'(cfg.row_width);
		if (cfg.row_count == '0)
			h = HW'(1);
		else if (32'(cfg.row_count) > MAX_ROWS)
			h = HW'(MAX_ROWS);
		else
			h = HW'(cfg.row_count);
	end

	// counters left beyond a shrunken limit restart at zero
	always_comb begin
		lcol      = (WW'(load_col_q) >= w) ? '0 : load_col_q;
		lwrap     = (WW'(lcol) + WW'(1)) >= w;
		ecol      = (WW'(emit_col_q) >= w) ? '0 : emit_col_q;
		row       = (HW'(row_q) >= h) ? '0 : row_q;
		first     = (ecol == '0);
		rlast     = (WW'(ecol) + WW'(1)) >= w;
		flast     = rlast && ((HW'(row) + HW'(1)) >= h);
		phase_cur = (first && row == '0) ? cfg.start_phase : phase_acc_q;
		rom_idx   = phase_cur[15 -: LN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q  <= '0;
			emit_col_q  <= '0;
			row_q       <= '0;
			phase_acc_q <= '0;
		end else if (acc) begin
			if (!action) begin
				load_col_q <= lwrap ? '0 : lcol + CW'(1);
			end else begin
				emit_col_q  <= rlast ? '0 : ecol + CW'(1);
				row_q       <= rlast ? (flast ? '0 : row + RW'(1)) : row;
				phase_acc_q <= rlast ? phase_cur + cfg.phase_step : phase_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= acc;
			if (acc) begin
				ctl_s1.emit  <= action;
				ctl_s1.first <= action && first;
				ctl_s1.rlast <= rlast;
				ctl_s1.flast <= flast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			col_s1 <= action ? ecol : lcol;
	end

	a_phase_reload: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action && first && row == '0 && !rlast |=>
			phase_acc_q == $past(cfg.start_phase))
		else $error("phase not reloaded at frame start");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action && flast |=> row_q == '0 && emit_col_q == '0)
		else $error("counters not cleared after last pixel of frame");

	// row and frame flags only mean something on an emit
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.emit && ctl_s1.flast |-> ctl_s1.rlast)
		else $error("frame end flagged without row end");

endmodule

/* src/sine_row_shift_raster.sv */
// sine_row_shift_raster: top level; handshake, offset multiply, line store and result stage.
// Depends on srs_pkg, srs_if, srs_ram, srs_sine_rom, srs_regs, srs_seq.
//
//  channel   dir  handshake       carries
//  pix_in    in   valid/ready     action, src_pixel, dst_pixel
//  pix_out   out  valid/ready     out_pixel, row_last, frame_last
//  apb       in   psel/penable    row_width, row_count, amplitude, start_phase, phase_step
//
// One transaction per clock while pix_out is not stalled; a result passes stages 1, 2 and 3.
// Stage 1 reads the sine table, stage 2 multiplies and addresses the line store,
// stage 3 holds the line store read and picks source or destination pixel.
// Reset clears counters, the row offset and valid bits; the line store needs no clearing.
// A result not taken holds the whole pipeline and drops pix_in.ready.

module sine_row_shift_raster #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_ROWS     = 1024,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	srs_in_if.sink                         pix_in,
	srs_out_if.source                      pix_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [srs_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	import srs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int LN = $clog2(SINE_ENTRIES);
	localparam int JW = ((CW > 12) ? CW : 12) + 2;

	cfg_t          cfg;
	logic          adv;
	logic          acc;
	logic [WW-1:0] w;
	logic [LN-1:0] rom_idx;

	ctl_t          ctl_s1;
	logic [CW-1:0] col_s1;
	logic [31:0]   src_s1;
	logic [31:0]   dst_s1;
	logic [14:0]   mag_s1;
	logic          neg_s1;

	ctl_t          ctl_s2;
	logic [CW-1:0] col_s2;
	logic [31:0]   src_s2;
	logic [31:0]   dst_s2;
	logic [26:0]   prod_s2;
	logic          neg_s2;

	logic signed [12:0]   row_offset_q;
	logic [11:0]          mag_d;
	logic signed [12:0]   d_new;
	logic signed [12:0]   off;
	logic signed [JW-1:0] j;
	logic                 in_rng;
	logic                 ram_we;
	logic                 ram_re;
	logic [CW-1:0]        raddr;
	logic [31:0]          rdata;

	logic        vld_s3;
	logic        sel_s3;
	logic [31:0] dst_s3;
	logic        rlast_s3;
	logic        flast_s3;

	srs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv          = !vld_s3 || pix_out.ready;
	assign acc          = pix_in.valid && adv;
	assign pix_in.ready = adv;

	srs_seq #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_ROWS     (MAX_ROWS),
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.acc     (acc),
		.action  (pix_in.action),
		.cfg     (cfg),
		.ctl_s1  (ctl_s1),
		.col_s1  (col_s1),
		.rom_idx (rom_idx),
		.w       (w)
	);

	srs_sine_rom #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_rom (
		.clk (clk),
		.en  (acc),
		.idx (rom_idx),
		.mag (mag_s1),
		.neg (neg_s1)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			src_s1 <= pix_in.src_pixel;
			dst_s1 <= pix_in.dst_pixel;
		end
	end

	// stage 2: |sin| * amplitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s2 <= '0;
		else if (adv)
			ctl_s2 <= ctl_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s2  <= col_s1;
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			prod_s2 <= 27'(mag_s1) * 27'(cfg.amplitude);
			neg_s2  <= neg_s1;
		end
	end

	// shift on magnitude, then sign: truncates toward zero
	always_comb begin
		mag_d  = prod_s2[26:15];
		d_new  = neg_s2 ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
		off    = ctl_s2.first ? d_new : row_offset_q;
		j      = $signed({{(JW-CW){1'b0}}, col_s2}) - JW'(off);
		in_rng = !j[JW-1] && (j < $signed({{(JW-WW){1'b0}}, w}));
		raddr  = in_rng ? j[CW-1:0] : '0;
		ram_we = adv && ctl_s2.valid && !ctl_s2.emit;
		ram_re = adv && ctl_s2.valid && ctl_s2.emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_offset_q <= '0;
		else if (ram_re && ctl_s2.first)
			row_offset_q <= d_new;
	end

	srs_ram #(
		.WIDTH (32),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s2),
		.wdata (src_s2),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv)
			vld_s3 <= ctl_s2.valid && ctl_s2.emit;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s3   <= in_rng;
			dst_s3   <= dst_s2;
			rlast_s3 <= ctl_s2.rlast;
			flast_s3 <= ctl_s2.flast;
		end
	end

	assign pix_out.valid      = vld_s3;
	assign pix_out.out_pixel  = sel_s3 ? rdata : dst_s3;
	assign pix_out.row_last   = rlast_s3;
	assign pix_out.frame_last = flast_s3;

	a_wr_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> WW'(col_s2) < w)
		else $error("line store write beyond row width");

	a_offset_held: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re && ctl_s2.first |=> row_offset_q == $past(d_new))
		else $error("row offset not captured at row start");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !pix_out.ready |=> vld_s3 && $stable(sel_s3) && $stable(dst_s3))
		else $error("result stage changed while stalled");

	a_last_flags: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> !flast_s3 || rlast_s3)
		else $error("frame end without row end on result");

endmodule

/* tb/sine_row_shift_raster_tb.sv */
`timescale 1ns / 100ps
// sine_row_shift_raster_tb: self-checking testbench for the sine row shift raster block.
// Drives pixel load/emit transactions and APB register writes, predicts every result pixel.
// Depends on srs_pkg, srs_if and sine_row_shift_raster.

module sine_row_shift_raster_tb;
	import srs_pkg::*;

	localparam int     LINE_MAX         = 1024;
	localparam int     ROWS_MAX         = 1024;
	localparam int     LUT_SIZE         = 1024;
	localparam int     QUARTER          = LUT_SIZE / 4;
	localparam longint TURN_Q30         = 64'sd6746518852;
	localparam int     SETTLE_CYCLES    = 8;
	localparam int     IDLE_LIMIT       = 4000;
	localparam int     RANDOM_ITEMS     = 340;
	localparam int     SHOWN_MISMATCHES = 10;

	typedef enum logic {ACT_LOAD = 1'b0, ACT_EMIT = 1'b1} action_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_CHOKE} rx_mode_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        row_last;
		logic        frame_last;
	} shifted_px_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	srs_in_if  pix_in_bus ();
	srs_out_if pix_out_bus ();

	sine_row_shift_raster dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the block: line store, counters, phase and registers
	int          sine_lut [LUT_SIZE];
	logic [31:0] line_buf [LINE_MAX];
	bit          line_valid [LINE_MAX];
	int unsigned ld_col;
	int unsigned em_col;
	int unsigned row_no;
	logic [15:0] phase_now;
	int          shift_px;
	logic [10:0] cfg_width;
	logic [10:0] cfg_rows;
	logic [11:0] cfg_amp;
	logic [15:0] cfg_start;
	logic [15:0] cfg_step;

	shifted_px_t pending_px [$];
	shifted_px_t head_px;

	int unsigned n_bad;
	int unsigned n_loads;
	int unsigned n_emits;
	int unsigned n_frames;
	int unsigned n_cfg;
	int unsigned idle_cycles;
	int unsigned burst_left;
	bit          gaps_on;
	rx_mode_t    rx_mode;
	int unsigned rx_span;
	int unsigned rx_tick;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sin(2*pi*k/LUT_SIZE) in Q1.15 over the first quarter, Taylor series in Q30
	function automatic int quarter_wave(int k);
		longint ang;
		longint ang2;
		longint term;
		longint sum;
		longint r;
		ang = (TURN_Q30 * longint'(k)) / LUT_SIZE;
		ang2 = (ang * ang) >>> 30;
		term = ang;
		sum = 0;
		for (int n = 1; n <= 12; n++) begin
			if (n % 2 == 1)
				sum = sum + term;
			else
				sum = sum - term;
			term = ((term * ang2) >>> 30) / longint'((2 * n) * (2 * n + 1));
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 64'sd16384) >>> 15;
		if (r > 32767)
			r = 32767;
		return int'(r);
	endfunction

	function automatic int unsigned eff_limit(logic [10:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : int'(v);
	endfunction

	// the next emit picks either the destination or a column loaded since reset
	function automatic bit emit_reads_loaded();
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		logic [15:0] ph;
		int          prod;
		int          d;
		int          j;
		w = eff_limit(cfg_width, LINE_MAX);
		h = eff_limit(cfg_rows, ROWS_MAX);
		col = (em_col >= w) ? 0 : em_col;
		row = (row_no >= h) ? 0 : row_no;
		d = shift_px;
		if (col == 0) begin
			ph = (row == 0) ? cfg_start : phase_now;
			prod = sine_lut[(32'(ph) * LUT_SIZE) >> 16] * int'(cfg_amp);
			d = (prod >= 0) ? (prod >>> 15) : -((-prod) >>> 15);
		end
		j = int'(col) - d;
		if (j < 0 || j >= int'(w))
			return 1'b1;
		return line_valid[j];
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		n_bad++;
		if (n_bad <= SHOWN_MISMATCHES)
			$display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
	endfunction

	function automatic logic [31:0] reg_shadow(reg_idx_t r);
		case (r)
			REG_ROW_WIDTH:   return 32'(cfg_width);
			REG_ROW_COUNT:   return 32'(cfg_rows);
			REG_AMPLITUDE:   return 32'(cfg_amp);
			REG_START_PHASE: return 32'(cfg_start);
			default:         return 32'(cfg_step);
		endcase
	endfunction

	// one accepted pixel transaction: update the shadow, queue the expected pixel
	function automatic void shift_predict(action_t act, logic [31:0] src, logic [31:0] dst);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		int          prod;
		int          j;
		shifted_px_t px;
		w = eff_limit(cfg_width, LINE_MAX);
		h = eff_limit(cfg_rows, ROWS_MAX);
		if (act == ACT_LOAD) begin
			col = (ld_col >= w) ? 0 : ld_col;
			line_buf[col] = src;
			line_valid[col] = 1'b1;
			ld_col = (col + 1 >= w) ? 0 : col + 1;
			return;
		end
		col = (em_col >= w) ? 0 : em_col;
		row = (row_no >= h) ? 0 : row_no;
		if (col == 0) begin
			if (row == 0)
				phase_now = cfg_start;
			prod = sine_lut[(32'(phase_now) * LUT_SIZE) >> 16] * int'(cfg_amp);
			// truncate toward zero
			shift_px = (prod >= 0) ? (prod >>> 15) : -((-prod) >>> 15);
		end
		j = int'(col) - shift_px;
		px.pixel = (j >= 0 && j < int'(w)) ? line_buf[j] : dst;
		px.row_last = (col + 1 >= w);
		px.frame_last = px.row_last && (row + 1 >= h);
		if (px.row_last) begin
			em_col = 0;
			phase_now = phase_now + cfg_step;
			row_no = px.frame_last ? 0 : row + 1;
		end else begin
			em_col = col + 1;
			row_no = row;
		end
		pending_px.push_back(px);
	endfunction

	task automatic send_pixel(action_t act, logic [31:0] src, logic [31:0] dst);
		int unsigned gap;
		// an emit may only read columns loaded since reset
		if (act == ACT_EMIT && !emit_reads_loaded())
			act = ACT_LOAD;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				pix_in_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.action <= act;
		pix_in_bus.src_pixel <= src;
		pix_in_bus.dst_pixel <= dst;
		do @(posedge clk); while (pix_in_bus.ready !== 1'b1);
		shift_predict(act, src, dst);
		if (act == ACT_EMIT)
			n_emits++;
		else
			n_loads++;
	endtask

	// stop sending and let the pipeline empty before touching registers
	task automatic settle();
		@(negedge clk);
		pix_in_bus.valid <= 1'b0;
		burst_left = 0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(bit wr, reg_idx_t r, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(reg_idx_t r, int unsigned v);
		logic [31:0] rd;
		apb_transfer(1'b1, r, v, rd);
		case (r)
			REG_ROW_WIDTH:   cfg_width = v[10:0];
			REG_ROW_COUNT:   cfg_rows = v[10:0];
			REG_AMPLITUDE:   cfg_amp = v[11:0];
			REG_START_PHASE: cfg_start = v[15:0];
			default:         cfg_step = v[15:0];
		endcase
		n_cfg++;
		apb_transfer(1'b0, r, '0, rd);
		if (rd !== reg_shadow(r))
			flag_mismatch($sformatf("readback of %s", r.name()), reg_shadow(r), rd);
	endtask

	task automatic test_register_reset();
		logic [31:0] rd;
		reg_idx_t    r;
		for (int i = REG_ROW_WIDTH; i <= REG_PHASE_STEP; i++) begin
			r = reg_idx_t'(i);
			apb_transfer(1'b0, r, '0, rd);
			if (rd !== reg_shadow(r))
				flag_mismatch($sformatf("reset value of %s", r.name()), reg_shadow(r), rd);
		end
	endtask

	// full-scale shift both ways, then a one-pixel shift both ways
	task automatic test_shift_extremes();
		logic [31:0] corner_px [4];
		corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5};
		set_reg(REG_ROW_WIDTH, 4);
		set_reg(REG_ROW_COUNT, 2);
		set_reg(REG_AMPLITUDE, 4095);
		set_reg(REG_START_PHASE, 16'h4000);
		set_reg(REG_PHASE_STEP, 16'h8000);
		for (int row = 0; row < 2; row++) begin
			for (int i = 0; i < 4; i++)
				send_pixel(ACT_LOAD, corner_px[i], ~corner_px[i]);
			for (int i = 0; i < 4; i++)
				send_pixel(ACT_EMIT, ~corner_px[i], corner_px[3 - i]);
		end
		settle();
		set_reg(REG_AMPLITUDE, 2);
		for (int i = 0; i < 8; i++)
			send_pixel(ACT_EMIT, '0, corner_px[i % 4] ^ 32'h0F0F_0F0F);
	endtask

	// counters left beyond a shrunken width and row count restart at zero
	task automatic test_limit_shrink();
		settle();
		set_reg(REG_ROW_WIDTH, 6);
		set_reg(REG_ROW_COUNT, 8);
		set_reg(REG_AMPLITUDE, 0);
		repeat (6) send_pixel(ACT_LOAD, $urandom, $urandom);
		repeat (33) send_pixel(ACT_EMIT, $urandom, $urandom);
		settle();
		set_reg(REG_ROW_WIDTH, 2);
		set_reg(REG_ROW_COUNT, 3);
		set_reg(REG_AMPLITUDE, 3000);
		set_reg(REG_START_PHASE, $urandom_range(0, 16'hFFFF));
		repeat (8) send_pixel(ACT_EMIT, $urandom, $urandom);
	endtask

	// width zero (one pixel) and a saturated row count: the first rows of a tall frame
	task automatic test_tall_frame();
		settle();
		set_reg(REG_ROW_WIDTH, 0);
		set_reg(REG_ROW_COUNT, 2047);
		set_reg(REG_AMPLITUDE, $urandom_range(0, 4095));
		set_reg(REG_PHASE_STEP, $urandom_range(0, 16'hFFFF));
		send_pixel(ACT_LOAD, $urandom, $urandom);
		repeat (40)
			send_pixel(($urandom_range(0, 9) == 0) ? ACT_LOAD : ACT_EMIT, $urandom, $urandom);
	endtask

	// saturated width: the opening columns of a long line, small shifts
	task automatic test_wide_row();
		settle();
		set_reg(REG_ROW_WIDTH, 2047);
		set_reg(REG_ROW_COUNT, 2);
		set_reg(REG_AMPLITUDE, $urandom_range(1, 24));
		set_reg(REG_START_PHASE, $urandom_range(0, 16'hFFFF));
		set_reg(REG_PHASE_STEP, 16'h1000);
		repeat (40) send_pixel(ACT_LOAD, $urandom, $urandom);
		repeat (56) send_pixel(ACT_EMIT, $urandom, $urandom);
	endtask

	// random settings; mostly whole rows (load then emit), some mixed noise
	task automatic test_random_rows();
		int unsigned random_items;
		int unsigned w;
		int unsigned n;
		int unsigned v;
		bit          first_phase;
		random_items = 0;
		first_phase = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			gaps_on = ($urandom_range(0, 3) != 0);
			if (first_phase || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       v = 0;
					1:       v = 1;
					2:       v = $urandom_range(25, 64);
					default: v = $urandom_range(2, 24);
				endcase
				set_reg(REG_ROW_WIDTH, v);
			end
			if (first_phase || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 7))
					0:       v = 0;
					1:       v = 1;
					2:       v = 2047;
					default: v = $urandom_range(1, 6);
				endcase
				set_reg(REG_ROW_COUNT, v);
			end
			if (first_phase || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
					0:       v = 0;
					1:       v = 4095;
					2:       v = $urandom_range(0, 4095);
					default: v = $urandom_range(1, 40);
				endcase
				set_reg(REG_AMPLITUDE, v);
			end
			if (first_phase || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 3))
					0:       v = 0;
					1:       v = 16'hFFFF;
					default: v = $urandom_range(0, 16'hFFFF);
				endcase
				set_reg(REG_START_PHASE, v);
			end
			if (first_phase || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 3))
					0:       v = 0;
					1:       v = 16'hFFFF;
					default: v = $urandom_range(0, 16'hFFFF);
				endcase
				set_reg(REG_PHASE_STEP, v);
			end
			first_phase = 1'b0;
			w = eff_limit(cfg_width, LINE_MAX);
			repeat ($urandom_range(1, 5)) begin
				if (random_items >= RANDOM_ITEMS)
					break;
				if ($urandom_range(0, 4) != 0) begin
					repeat (w) send_pixel(ACT_LOAD, $urandom, $urandom);
					repeat (w) send_pixel(ACT_EMIT, $urandom, $urandom);
					random_items += 2 * w;
				end else begin
					n = $urandom_range(1, 2 * w);
					repeat (n)
						send_pixel(action_t'($urandom_range(0, 1)), $urandom, $urandom);
					random_items += n;
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1) begin
			if (pending_px.size() == 0) begin
				flag_mismatch("result pixel with nothing expected", '0, pix_out_bus.out_pixel);
			end else begin
				head_px = pending_px.pop_front();
				if (pix_out_bus.out_pixel !== head_px.pixel)
					flag_mismatch("out_pixel", head_px.pixel, pix_out_bus.out_pixel);
				if (pix_out_bus.row_last !== head_px.row_last)
					flag_mismatch("row_last", 32'(head_px.row_last), 32'(pix_out_bus.row_last));
				if (pix_out_bus.frame_last !== head_px.frame_last)
					flag_mismatch("frame_last", 32'(head_px.frame_last),
						32'(pix_out_bus.frame_last));
				if (head_px.frame_last)
					n_frames++;
			end
		end
	end

	// result back-pressure: the mode is redrawn at random whenever its span runs out
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_span = $urandom_range(16, 96);
		end
		rx_span--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:    pix_out_bus.ready <= 1'b1;
			RX_COIN:    pix_out_bus.ready <= 1'($urandom_range(0, 1));
			RX_CADENCE: pix_out_bus.ready <= (rx_tick % 4 != 3);
			default:    pix_out_bus.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready)
				|| (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		pix_in_bus.valid = 1'b0;
		pix_in_bus.action = ACT_LOAD;
		pix_in_bus.src_pixel = '0;
		pix_in_bus.dst_pixel = '0;
		pix_out_bus.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		n_bad = 0;
		n_loads = 0;
		n_emits = 0;
		n_frames = 0;
		n_cfg = 0;
		idle_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		rx_mode = RX_OPEN;
		rx_span = 0;
		rx_tick = 0;
		// quarter wave mirrored into a full turn
		for (int i = 0; i < LUT_SIZE; i++) begin
			case (i / QUARTER)
				0:       sine_lut[i] = quarter_wave(i % QUARTER);
				1:       sine_lut[i] = quarter_wave(QUARTER - i % QUARTER);
				2:       sine_lut[i] = -quarter_wave(i % QUARTER);
				default: sine_lut[i] = -quarter_wave(QUARTER - i % QUARTER);
			endcase
		end
		for (int i = 0; i < LINE_MAX; i++)
			line_valid[i] = 1'b0;
		ld_col = 0;
		em_col = 0;
		row_no = 0;
		phase_now = '0;
		shift_px = 0;
		cfg_width = 11'd1024;
		cfg_rows = 11'd1024;
		cfg_amp = '0;
		cfg_start = '0;
		cfg_step = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_shift_extremes();
		test_limit_shrink();
		test_tall_frame();
		test_wide_row();
		test_random_rows();
		settle();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d emits with %0d register writes; %0d frames completed.",
			n_loads, n_emits, n_cfg, n_frames);
		$display("Widths and row counts from zero to saturation, full-scale shifts, %0d mismatches.",
			n_bad);
		if (n_bad == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
